// ===== hw/rtl/srp_pkg.sv =====
package srp_pkg;

    localparam int REC_W   = 35;
    localparam int ROW_W   = 32;
    localparam int STYLE_W = 24;
    localparam int RAW_W   = 64;

    // event codes
    localparam logic [1:0] EV_ROW   = 2'd0;
    localparam logic [1:0] EV_CELL  = 2'd1;
    localparam logic [1:0] EV_END   = 2'd2;
    localparam logic [1:0] EV_ERROR = 2'd3;

    // record ids
    localparam logic [REC_W-1:0] ID_ROW       = 35'h0;
    localparam logic [REC_W-1:0] ID_CELL_LO   = 35'h1;
    localparam logic [REC_W-1:0] ID_CELL_HI   = 35'hB;
    localparam logic [REC_W-1:0] ID_SHEET_END = 35'h92;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [REC_W-1:0]   record_kind;
        logic [ROW_W-1:0]   row_number;
        logic [ROW_W-1:0]   empty_rows_before;
        logic [ROW_W-1:0]   column_offset;
        logic [STYLE_W-1:0] style_index;
        logic [RAW_W-1:0]   raw_value;
    } t_result;

    // results of one byte: up to two, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_step;

endpackage

// ===== hw/rtl/srp_core.sv =====
module srp_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    output srp_pkg::t_step o_step
);

    typedef enum logic [1:0] {
        PH_ID,
        PH_LEN,
        PH_BODY
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [srp_pkg::REC_W-1:0]       r_acc, n_acc;
    logic [2:0]                      r_vcnt, n_vcnt;
    logic [srp_pkg::REC_W-1:0]       r_rec_id, n_rec_id;
    logic [srp_pkg::REC_W-1:0]       r_left, n_left;
    logic [4:0]                      r_boff, n_boff;
    logic [63:0]                     r_hdr, n_hdr;
    logic [63:0]                     r_body, n_body;
    logic [srp_pkg::ROW_W-1:0]       r_prev_row, n_prev_row;
    logic                            r_seen_first, n_seen_first;
    logic                            r_in_first, n_in_first;
    logic [srp_pkg::ROW_W-1:0]       r_low_col, n_low_col;
    logic                            r_low_valid, n_low_valid;
    logic                            r_finished, n_finished;

    logic [srp_pkg::REC_W-1:0]       shifted;
    logic                            do_finish;
    logic                            rec_valid;
    srp_pkg::t_result                rec_res;
    logic                            end_valid;
    srp_pkg::t_result                end_res;
    logic [srp_pkg::ROW_W-1:0]       row_nr;
    logic [srp_pkg::ROW_W-1:0]       col;

    // place the 7 payload bits of this varint byte
    always_comb begin
        case (r_vcnt)
            3'd0:    shifted = {28'd0, i_data_byte[6:0]};
            3'd1:    shifted = {21'd0, i_data_byte[6:0], 7'd0};
            3'd2:    shifted = {14'd0, i_data_byte[6:0], 14'd0};
            3'd3:    shifted = {7'd0, i_data_byte[6:0], 21'd0};
            3'd4:    shifted = {i_data_byte[6:0], 28'd0};
            default: shifted = '0;
        endcase
    end

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_vcnt       = r_vcnt;
        n_rec_id     = r_rec_id;
        n_left       = r_left;
        n_boff       = r_boff;
        n_hdr        = r_hdr;
        n_body       = r_body;
        n_prev_row   = r_prev_row;
        n_seen_first = r_seen_first;
        n_in_first   = r_in_first;
        n_low_col    = r_low_col;
        n_low_valid  = r_low_valid;
        n_finished   = r_finished;
        do_finish    = 1'b0;
        rec_valid    = 1'b0;
        rec_res      = '0;
        end_valid    = 1'b0;
        end_res      = '0;
        row_nr       = '0;
        col          = '0;

        if (i_valid && !r_finished) begin
            if (r_phase == PH_BODY) begin
                if (r_boff < 5'd8) begin
                    n_hdr[{r_boff[2:0], 3'b000} +: 8] = i_data_byte;
                end else if (r_boff < 5'd16) begin
                    n_body[{r_boff[2:0], 3'b000} +: 8] = i_data_byte;
                end
                if (r_boff < 5'd16) begin
                    n_boff = r_boff + 5'd1;
                end
                n_left = r_left - 35'd1;
                if (n_left == '0 || i_last_byte) begin
                    do_finish = 1'b1;
                    n_phase   = PH_ID;
                end
            end else begin
                n_acc  = r_acc | shifted;
                n_vcnt = r_vcnt + 3'd1;
                if (i_data_byte[7]) begin
                    // continuation: overlong or cut varint is a framing error
                    if (n_vcnt >= 3'd5 || i_last_byte) begin
                        rec_valid            = 1'b1;
                        rec_res.event_kind   = srp_pkg::EV_ERROR;
                        n_finished           = 1'b1;
                    end
                end else if (r_phase == PH_ID) begin
                    n_rec_id = n_acc;
                    n_acc    = '0;
                    n_vcnt   = '0;
                    n_phase  = PH_LEN;
                    if (i_last_byte) begin
                        rec_valid          = 1'b1;
                        rec_res.event_kind = srp_pkg::EV_ERROR;
                        n_finished         = 1'b1;
                    end
                end else begin
                    n_left = n_acc;
                    n_acc  = '0;
                    n_vcnt = '0;
                    n_boff = '0;
                    n_hdr  = '0;
                    n_body = '0;
                    if (n_left == '0 || i_last_byte) begin
                        do_finish = 1'b1;
                        n_phase   = PH_ID;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end

            if (do_finish) begin
                row_nr = n_hdr[31:0];
                col    = n_hdr[31:0];
                if (r_rec_id == srp_pkg::ID_ROW) begin
                    rec_valid          = 1'b1;
                    rec_res.event_kind = srp_pkg::EV_ROW;
                    rec_res.row_number = row_nr;
                    if (r_seen_first) begin
                        n_in_first = 1'b0;
                        if (row_nr > r_prev_row) begin
                            rec_res.empty_rows_before = row_nr - r_prev_row - 32'd1;
                        end
                    end
                    n_seen_first = 1'b1;
                    n_prev_row   = row_nr;
                end else if (r_seen_first) begin
                    if (r_rec_id inside {[srp_pkg::ID_CELL_LO:srp_pkg::ID_CELL_HI]}) begin
                        if (n_boff >= 5'd8) begin
                            rec_valid           = 1'b1;
                            rec_res.event_kind  = srp_pkg::EV_CELL;
                            rec_res.record_kind = r_rec_id;
                            rec_res.row_number  = r_prev_row;
                            rec_res.style_index = n_hdr[55:32];
                            rec_res.raw_value   = n_body;
                            if (r_in_first && (!r_low_valid || col < r_low_col)) begin
                                n_low_col   = col;
                                n_low_valid = 1'b1;
                            end
                            // a new minimum gives offset zero, same as no offset
                            if (r_low_valid && col > r_low_col) begin
                                rec_res.column_offset = col - r_low_col;
                            end
                        end
                    end else if (r_rec_id == srp_pkg::ID_SHEET_END) begin
                        rec_valid           = 1'b1;
                        rec_res.event_kind  = srp_pkg::EV_END;
                        rec_res.record_kind = srp_pkg::ID_SHEET_END;
                        n_finished          = 1'b1;
                    end
                end
            end

            if (i_last_byte && !n_finished) begin
                end_valid          = 1'b1;
                end_res.event_kind = srp_pkg::EV_END;
                n_finished         = 1'b1;
            end
        end

        o_step = '0;
        if (rec_valid) begin
            o_step.count  = end_valid ? 2'd2 : 2'd1;
            o_step.first  = rec_res;
            o_step.second = end_res;
        end else begin
            o_step.count = end_valid ? 2'd1 : 2'd0;
            o_step.first = end_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_ID;
            r_acc        <= '0;
            r_vcnt       <= '0;
            r_rec_id     <= '0;
            r_left       <= '0;
            r_boff       <= '0;
            r_hdr        <= '0;
            r_body       <= '0;
            r_prev_row   <= '0;
            r_seen_first <= 1'b0;
            r_in_first   <= 1'b1;
            r_low_col    <= '0;
            r_low_valid  <= 1'b0;
            r_finished   <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_vcnt       <= n_vcnt;
            r_rec_id     <= n_rec_id;
            r_left       <= n_left;
            r_boff       <= n_boff;
            r_hdr        <= n_hdr;
            r_body       <= n_body;
            r_prev_row   <= n_prev_row;
            r_seen_first <= n_seen_first;
            r_in_first   <= n_in_first;
            r_low_col    <= n_low_col;
            r_low_valid  <= n_low_valid;
            r_finished   <= n_finished;
        end
    end

    a_quiet_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> o_step.count == 2'd0)
        else $error("result produced after the sheet ended");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.count == 2'd2 |->
            o_step.first.event_kind != srp_pkg::EV_ERROR &&
            o_step.second.event_kind == srp_pkg::EV_END)
        else $error("bad result pair");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last_byte && !r_finished |=> r_finished)
        else $error("final byte did not end the sheet");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_step.count != 2'd3)
        else $error("more than two results for one byte");

endmodule

// ===== hw/rtl/srp_queue.sv =====
module srp_queue #(
    parameter int DEPTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  srp_pkg::t_step                i_step,
    input  logic                          i_stall,
    output logic                          o_valid,
    output srp_pkg::t_result              o_head,
    output logic [$clog2(DEPTH+1)-1:0]    o_level
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    srp_pkg::t_result r_slot [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [LW-1:0]    r_count, n_count;
    logic [PW-1:0]    wr_next;
    logic             pop;
    logic [LW:0]      fill_sum;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        logic [PW-1:0] q;
        begin
            q = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
            return q;
        end
    endfunction

    assign o_valid  = (r_count != '0);
    assign o_head   = r_slot[r_rd_ptr];
    assign o_level  = r_count;
    assign pop      = o_valid && !i_stall;
    assign wr_next  = ptr_inc(r_wr_ptr);
    assign fill_sum = (LW+1)'(r_count) + (LW+1)'(i_step.count);

    always_comb begin
        n_count  = LW'(fill_sum - (LW+1)'(pop));
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        case (i_step.count)
            2'd1:    n_wr_ptr = wr_next;
            2'd2:    n_wr_ptr = ptr_inc(wr_next);
            default: n_wr_ptr = r_wr_ptr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_step.count != 2'd0) begin
            r_slot[r_wr_ptr] <= i_step.first;
        end
        if (i_step.count == 2'd2) begin
            r_slot[wr_next] <= i_step.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_sum <= (LW+1)'(DEPTH))
        else $error("result queue overflow");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_wr_ptr == r_rd_ptr)
        else $error("empty queue with unequal pointers");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LW'(DEPTH))
        else $error("queue level above depth");

endmodule

// ===== hw/rtl/sheet_record_stream_parser.sv =====
// Worksheet record stream parser.
//
// Input channel: one stream byte per word on i_data_byte, with i_last_byte
// marking the final byte. A word is taken when i_in_valid is high and
// o_in_stall is low. Output channel: one event per word on the o_* result
// ports (row start, cell, sheet end, framing error), taken when o_out_valid
// is high and i_out_stall is low.
//
// Throughput: one byte per cycle while o_in_stall is low. Each byte passes
// an input register, then one pass of the varint/body parser whose results
// land in a small result queue of QUEUE_DEPTH entries. A byte yields zero,
// one or two events. o_in_stall keeps room for two events per byte in
// flight: it rises once more than QUEUE_DEPTH-4 events wait with a byte in
// the input register (QUEUE_DEPTH-2 without), so a stalling receiver or
// two-event bytes stall the input as the queue nears full. Held events do
// not change.
//
// Reset (synchronous, i_rst_n low) empties the queue and returns the parser
// to the start of a sheet. Once a sheet ends or a framing error is found,
// further bytes are dropped without events until the next reset.
module sheet_record_stream_parser #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_data_byte,
    input  logic                           i_last_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_event_kind,
    output logic [srp_pkg::REC_W-1:0]      o_record_kind,
    output logic [srp_pkg::ROW_W-1:0]      o_row_number,
    output logic [srp_pkg::ROW_W-1:0]      o_empty_rows_before,
    output logic [srp_pkg::ROW_W-1:0]      o_column_offset,
    output logic [srp_pkg::STYLE_W-1:0]    o_style_index,
    output logic [srp_pkg::RAW_W-1:0]      o_raw_value
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LW + 2;

    // input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    srp_pkg::t_step   step;
    srp_pkg::t_result head;
    logic [LW-1:0]    level;
    logic [SW-1:0]    need;
    logic             in_take;

    // Reserve room for two events from the byte in the input register and
    // two from the byte that would be taken now.
    assign need       = SW'(level) + (r_in_valid ? SW'(4) : SW'(2));
    assign o_in_stall = need > SW'(QUEUE_DEPTH);
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take;
        end
    end

    // payload: hold when no word is taken
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    srp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (r_in_valid),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_step      (step)
    );

    srp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_head  (head),
        .o_level (level)
    );

    assign o_event_kind        = head.event_kind;
    assign o_record_kind       = head.record_kind;
    assign o_row_number        = head.row_number;
    assign o_empty_rows_before = head.empty_rows_before;
    assign o_column_offset     = head.column_offset;
    assign o_style_index       = head.style_index;
    assign o_raw_value         = head.raw_value;

endmodule
